// ===== design/frc_pkg.sv =====
// Package for the checked record deframer: widths, reset values, codes
// and the structs passed between the deframer modules. No dependencies.
package frc_pkg;

  localparam int unsigned MaxPayloadLength = 4096;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 13;
  localparam int unsigned SumW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] MagicReset   = 8'hbe;
  localparam logic [ByteW-1:0] VersionReset = 8'h00;
  localparam logic [LenW-1:0]  LengthReset  = 13'd256;

  typedef enum logic [2:0] {
    PH_AWAIT,
    PH_HUNT,
    PH_VERSION,
    PH_CK_LO,
    PH_CK_HI,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MAGIC   = 3'd1,
    ST_VERSION = 3'd2,
    ST_TRUNC   = 3'd3,
    ST_CKSUM   = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAGIC   = 2'd0,
    CFG_VERSION = 2'd1,
    CFG_LENGTH  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] magic;
    logic [ByteW-1:0] version;
    logic [LenW-1:0]  length;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             payload_valid;
    logic             record_end;
    status_e          status;
    logic [SumW-1:0]  checksum;
  } result_t;

endpackage

// ===== design/frc_cfg.sv =====
// Configuration registers of the record deframer: magic, version, length.
// Depends on frc_pkg.
module frc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [frc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [frc_pkg::LenW-1:0]    cfg_data_i,
  output frc_pkg::cfg_t               cfg_o
);

  frc_pkg::cfg_t cfg_q;
  frc_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (frc_pkg::cfg_idx_e'(cfg_index_i))
        frc_pkg::CFG_MAGIC:   cfg_d.magic   = cfg_data_i[frc_pkg::ByteW-1:0];
        frc_pkg::CFG_VERSION: cfg_d.version = cfg_data_i[frc_pkg::ByteW-1:0];
        frc_pkg::CFG_LENGTH:  cfg_d.length  = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic   <= frc_pkg::MagicReset;
      cfg_q.version <= frc_pkg::VersionReset;
      cfg_q.length  <= frc_pkg::LengthReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/frc_step.sv =====
// Record phase machine and Fletcher-16 sums; one byte per fire.
// Depends on frc_pkg.
module frc_step #(
  parameter int unsigned MAX_PAYLOAD_LENGTH = frc_pkg::MaxPayloadLength
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  frc_pkg::cfg_t             cfg_i,
  input  logic                      fire_i,
  input  logic [frc_pkg::ByteW-1:0] byte_i,
  input  logic                      eos_i,
  output logic                      has_result_o,
  output frc_pkg::result_t          result_o
);

  localparam int unsigned CntW = $clog2(MAX_PAYLOAD_LENGTH + 1);
  localparam logic [frc_pkg::ByteW:0] FoldMod = 9'd255;

  frc_pkg::phase_e               phase_q, phase_d;
  logic [CntW-1:0]               seen_q, seen_d;
  logic [frc_pkg::ByteW-1:0]     low_q, low_d;
  logic [frc_pkg::ByteW-1:0]     high_q, high_d;
  logic [frc_pkg::SumW-1:0]      stored_q, stored_d;

  logic [CntW-1:0]               eff_len;
  logic [CntW-1:0]               seen_inc;
  logic [frc_pkg::ByteW:0]       low_add, high_add;
  logic [frc_pkg::ByteW-1:0]     low_new, high_new;
  logic [frc_pkg::SumW-1:0]      ck_new;
  logic                          last_byte;
  logic                          magic_hit;
  logic                          version_hit;

  always_comb begin
    if (cfg_i.length == '0) begin
      eff_len = CntW'(1);
    end else if (32'(cfg_i.length) > 32'(MAX_PAYLOAD_LENGTH)) begin
      eff_len = CntW'(MAX_PAYLOAD_LENGTH);
    end else begin
      eff_len = CntW'(cfg_i.length);
    end
  end

  assign low_add     = {1'b0, low_q} + {1'b0, byte_i};
  assign low_new     = (low_add >= FoldMod) ? 8'(low_add - FoldMod) : low_add[7:0];
  assign high_add    = {1'b0, high_q} + {1'b0, low_new};
  assign high_new    = (high_add >= FoldMod) ? 8'(high_add - FoldMod) : high_add[7:0];
  assign ck_new      = {high_new, low_new};
  assign seen_inc    = seen_q + CntW'(1);
  assign last_byte   = !(seen_inc < eff_len);
  assign magic_hit   = (byte_i == cfg_i.magic);
  assign version_hit = (byte_i == cfg_i.version);

  // next state
  always_comb begin
    phase_d  = phase_q;
    seen_d   = seen_q;
    low_d    = low_q;
    high_d   = high_q;
    stored_d = stored_q;
    if (fire_i) begin
      if (eos_i) begin
        phase_d  = frc_pkg::PH_AWAIT;
        seen_d   = '0;
        low_d    = '0;
        high_d   = '0;
        stored_d = '0;
      end else begin
        case (phase_q)
          frc_pkg::PH_AWAIT, frc_pkg::PH_HUNT: begin
            if (magic_hit) begin
              phase_d  = frc_pkg::PH_VERSION;
              seen_d   = '0;
              low_d    = '0;
              high_d   = '0;
              stored_d = '0;
            end else begin
              phase_d = frc_pkg::PH_HUNT;
            end
          end
          frc_pkg::PH_VERSION: begin
            if (version_hit) begin
              phase_d = frc_pkg::PH_CK_LO;
            end else begin
              phase_d  = frc_pkg::PH_HUNT;
              seen_d   = '0;
              low_d    = '0;
              high_d   = '0;
              stored_d = '0;
            end
          end
          frc_pkg::PH_CK_LO: begin
            stored_d = {8'h00, byte_i};
            phase_d  = frc_pkg::PH_CK_HI;
          end
          frc_pkg::PH_CK_HI: begin
            stored_d = {byte_i, stored_q[7:0]};
            seen_d   = '0;
            low_d    = '0;
            high_d   = '0;
            phase_d  = frc_pkg::PH_PAYLOAD;
          end
          frc_pkg::PH_PAYLOAD: begin
            if (last_byte) begin
              phase_d  = (ck_new == stored_q) ? frc_pkg::PH_AWAIT : frc_pkg::PH_HUNT;
              seen_d   = '0;
              low_d    = '0;
              high_d   = '0;
              stored_d = '0;
            end else begin
              seen_d = seen_inc;
              low_d  = low_new;
              high_d = high_new;
            end
          end
          default: phase_d = frc_pkg::PH_AWAIT;
        endcase
      end
    end
  end

  // result of the current byte
  always_comb begin
    has_result_o           = 1'b0;
    result_o.payload_byte  = '0;
    result_o.payload_valid = 1'b0;
    result_o.record_end    = 1'b0;
    result_o.status        = frc_pkg::ST_OK;
    result_o.checksum      = '0;
    if (eos_i) begin
      if (phase_q != frc_pkg::PH_AWAIT && phase_q != frc_pkg::PH_HUNT) begin
        has_result_o        = 1'b1;
        result_o.record_end = 1'b1;
        result_o.status     = frc_pkg::ST_TRUNC;
        if (phase_q == frc_pkg::PH_PAYLOAD) begin
          result_o.checksum = {high_q, low_q};
        end
      end
    end else begin
      case (phase_q)
        frc_pkg::PH_AWAIT: begin
          if (!magic_hit) begin
            has_result_o        = 1'b1;
            result_o.record_end = 1'b1;
            result_o.status     = frc_pkg::ST_MAGIC;
          end
        end
        frc_pkg::PH_VERSION: begin
          if (!version_hit) begin
            has_result_o        = 1'b1;
            result_o.record_end = 1'b1;
            result_o.status     = frc_pkg::ST_VERSION;
          end
        end
        frc_pkg::PH_PAYLOAD: begin
          has_result_o           = 1'b1;
          result_o.payload_byte  = byte_i;
          result_o.payload_valid = 1'b1;
          result_o.record_end    = last_byte;
          result_o.checksum      = ck_new;
          if (last_byte && ck_new != stored_q) begin
            result_o.status = frc_pkg::ST_CKSUM;
          end
        end
        default: has_result_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= frc_pkg::PH_AWAIT;
      seen_q   <= '0;
      low_q    <= '0;
      high_q   <= '0;
      stored_q <= '0;
    end else begin
      phase_q  <= phase_d;
      seen_q   <= seen_d;
      low_q    <= low_d;
      high_q   <= high_d;
      stored_q <= stored_d;
    end
  end

endmodule

// ===== design/fletcher_record_checker_top.sv =====
// Top level of the Fletcher-16 checked record deframer: input register,
// step logic, result register. Depends on frc_pkg, frc_cfg, frc_step.
//
//   channel | valid / stall            | payload
//   --------+--------------------------+---------------------------------------
//   in      | in_valid_i / in_stall_o  | byte_in_i, end_of_stream_i
//   out     | out_valid_o / out_stall_i| payload_byte_o, payload_valid_o,
//           |                          | record_end_o, status_o,
//           |                          | computed_checksum_o
//   cfg     | cfg_we_i (no stall)      | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_stall_i is low; an accepted item passes
// from the input register through the step logic into the result register.
// Reset is asynchronous and active low; it clears the record state and loads
// the configuration reset values.
// An out stall holds the result register and the input register; in_stall_o
// rises only while both are full.
module fletcher_record_checker_top #(
  parameter int unsigned MAX_PAYLOAD_LENGTH = frc_pkg::MaxPayloadLength
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [frc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [frc_pkg::LenW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [frc_pkg::ByteW-1:0]   byte_in_i,
  input  logic                        end_of_stream_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [frc_pkg::ByteW-1:0]   payload_byte_o,
  output logic                        payload_valid_o,
  output logic                        record_end_o,
  output logic [2:0]                  status_o,
  output logic [frc_pkg::SumW-1:0]    computed_checksum_o
);

  frc_pkg::cfg_t             cfg;
  frc_pkg::result_t          step_res;
  logic                      step_has;

  logic                      in_valid_q, in_valid_d;
  logic [frc_pkg::ByteW-1:0] in_byte_q;
  logic                      in_eos_q;
  logic                      out_valid_q, out_valid_d;
  frc_pkg::result_t          out_res_q;

  logic                      advance;
  logic                      fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  assign in_valid_d  = in_stall_o ? in_valid_q : in_valid_i;
  assign out_valid_d = advance ? (fire && step_has) : out_valid_q;

  frc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  frc_step #(
    .MAX_PAYLOAD_LENGTH (MAX_PAYLOAD_LENGTH)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .fire_i       (fire),
    .byte_i       (in_byte_q),
    .eos_i        (in_eos_q),
    .has_result_o (step_has),
    .result_o     (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= byte_in_i;
      in_eos_q  <= end_of_stream_i;
    end
    if (fire) begin
      out_res_q <= step_res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign payload_byte_o      = out_res_q.payload_byte;
  assign payload_valid_o     = out_res_q.payload_valid;
  assign record_end_o        = out_res_q.record_end;
  assign status_o            = out_res_q.status;
  assign computed_checksum_o = out_res_q.checksum;

endmodule

// ===== design/frc_checker.sv =====
// Port-level checks of the record deframer, bound to the top level.
// Depends on frc_pkg and fletcher_record_checker_top.
module frc_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [frc_pkg::ByteW-1:0] payload_byte_o,
  input logic                     payload_valid_o,
  input logic                     record_end_o,
  input logic [2:0]               status_o,
  input logic [frc_pkg::SumW-1:0] computed_checksum_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_byte_o)
      && $stable(status_o) && $stable(computed_checksum_o))
    else $error("stalled out item changed");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("in stall without a held out item");

  a_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !record_end_o |-> status_o == frc_pkg::ST_OK && payload_valid_o)
    else $error("open result without payload or with a status");

  a_header_error_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_end_o
      && (status_o == frc_pkg::ST_MAGIC || status_o == frc_pkg::ST_VERSION)
      |-> !payload_valid_o && payload_byte_o == '0 && computed_checksum_o == '0)
    else $error("header error carries payload data");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= frc_pkg::ST_CKSUM)
    else $error("status code out of range");

endmodule

bind fletcher_record_checker_top frc_checker u_frc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .payload_byte_o      (payload_byte_o),
  .payload_valid_o     (payload_valid_o),
  .record_end_o        (record_end_o),
  .status_o            (status_o),
  .computed_checksum_o (computed_checksum_o)
);

// ===== test/tb_fletcher_record_checker_top.sv =====
// Testbench for fletcher_record_checker_top: drives record byte streams with random
// idles and stalls, predicts every result in-bench and checks each result field.
// Depends on frc_pkg and the deframer RTL.
module tb_fletcher_record_checker_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [frc_pkg::ByteW-1:0] octet_q_t[$];

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [frc_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [frc_pkg::LenW-1:0]    cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [frc_pkg::ByteW-1:0]   byte_in_i = '0;
  logic                        end_of_stream_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [frc_pkg::ByteW-1:0]   payload_byte_o;
  logic                        payload_valid_o;
  logic                        record_end_o;
  logic [2:0]                  status_o;
  logic [frc_pkg::SumW-1:0]    computed_checksum_o;

  fletcher_record_checker_top uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .byte_in_i           (byte_in_i),
    .end_of_stream_i     (end_of_stream_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .payload_byte_o      (payload_byte_o),
    .payload_valid_o     (payload_valid_o),
    .record_end_o        (record_end_o),
    .status_o            (status_o),
    .computed_checksum_o (computed_checksum_o)
  );

  frc_pkg::result_t          frame_results_q[$];
  int                        err_count = 0;
  int                        items_sent = 0;
  int                        rx_hold = 0;
  bit                        tx_no_gaps = 1'b0;

  logic [frc_pkg::ByteW-1:0] cfg_magic = frc_pkg::MagicReset;
  logic [frc_pkg::ByteW-1:0] cfg_version = frc_pkg::VersionReset;
  logic [frc_pkg::LenW-1:0]  cfg_length = frc_pkg::LengthReset;

  frc_pkg::phase_e           rec_phase = frc_pkg::PH_AWAIT;
  int                        taken_count = 0;
  logic [frc_pkg::ByteW-1:0] lo_sum = '0;
  logic [frc_pkg::ByteW-1:0] hi_sum = '0;
  logic [frc_pkg::SumW-1:0]  record_ck = '0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void clear_record_sums();
    taken_count = 0;
    lo_sum = '0;
    hi_sum = '0;
    record_ck = '0;
  endfunction

  function automatic void advance_deframer(logic [frc_pkg::ByteW-1:0] b, logic eos);
    frc_pkg::result_t r;
    int               n;
    r = '0;
    if (eos) begin
      if (rec_phase == frc_pkg::PH_AWAIT || rec_phase == frc_pkg::PH_HUNT) begin
        rec_phase = frc_pkg::PH_AWAIT;
        clear_record_sums();
        return;
      end
      r.record_end = 1'b1;
      r.status = frc_pkg::ST_TRUNC;
      r.checksum = (rec_phase == frc_pkg::PH_PAYLOAD) ? {hi_sum, lo_sum} : '0;
      frame_results_q.push_back(r);
      rec_phase = frc_pkg::PH_AWAIT;
      clear_record_sums();
      return;
    end
    case (rec_phase)
      frc_pkg::PH_AWAIT: begin
        if (b == cfg_magic) begin
          clear_record_sums();
          rec_phase = frc_pkg::PH_VERSION;
        end else begin
          r.record_end = 1'b1;
          r.status = frc_pkg::ST_MAGIC;
          frame_results_q.push_back(r);
          rec_phase = frc_pkg::PH_HUNT;
        end
      end
      frc_pkg::PH_VERSION: begin
        if (b != cfg_version) begin
          r.record_end = 1'b1;
          r.status = frc_pkg::ST_VERSION;
          frame_results_q.push_back(r);
          rec_phase = frc_pkg::PH_HUNT;
          clear_record_sums();
        end else begin
          rec_phase = frc_pkg::PH_CK_LO;
        end
      end
      frc_pkg::PH_CK_LO: begin
        record_ck = {8'h00, b};
        rec_phase = frc_pkg::PH_CK_HI;
      end
      frc_pkg::PH_CK_HI: begin
        record_ck[15:8] = b;
        taken_count = 0;
        lo_sum = '0;
        hi_sum = '0;
        rec_phase = frc_pkg::PH_PAYLOAD;
      end
      frc_pkg::PH_PAYLOAD: begin
        lo_sum = 8'((int'(lo_sum) + int'(b)) % 255);
        hi_sum = 8'((int'(hi_sum) + int'(lo_sum)) % 255);
        taken_count++;
        r.payload_byte = b;
        r.payload_valid = 1'b1;
        r.checksum = {hi_sum, lo_sum};
        n = int'(cfg_length);
        if (n == 0) n = 1;
        if (n > int'(frc_pkg::MaxPayloadLength)) n = int'(frc_pkg::MaxPayloadLength);
        if (taken_count >= n) begin
          r.record_end = 1'b1;
          r.status = (r.checksum == record_ck) ? frc_pkg::ST_OK : frc_pkg::ST_CKSUM;
          rec_phase = (r.status == frc_pkg::ST_OK) ? frc_pkg::PH_AWAIT : frc_pkg::PH_HUNT;
          clear_record_sums();
        end
        frame_results_q.push_back(r);
      end
      default: begin
        if (b == cfg_magic) begin
          clear_record_sums();
          rec_phase = frc_pkg::PH_VERSION;
        end
      end
    endcase
  endfunction

  function automatic logic [frc_pkg::SumW-1:0] fletcher16(octet_q_t p);
    int lo;
    int hi;
    lo = 0;
    hi = 0;
    foreach (p[i]) begin
      lo = (lo + int'(p[i])) % 255;
      hi = (hi + lo) % 255;
    end
    return 16'(hi * 256 + lo);
  endfunction

  function automatic octet_q_t random_payload(int n);
    octet_q_t p;
    for (int i = 0; i < n; i++) p.push_back(8'($urandom_range(0, 255)));
    return p;
  endfunction

  function automatic octet_q_t build_record(logic [frc_pkg::ByteW-1:0] magic,
                                            logic [frc_pkg::ByteW-1:0] version,
                                            logic [frc_pkg::SumW-1:0] ck, octet_q_t p);
    octet_q_t q;
    q.push_back(magic);
    q.push_back(version);
    q.push_back(ck[7:0]);
    q.push_back(ck[15:8]);
    foreach (p[i]) q.push_back(p[i]);
    return q;
  endfunction

  function automatic int pick_gap();
    int r;
    if (tx_no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endfunction

  task automatic send_item(logic [frc_pkg::ByteW-1:0] b, logic eos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i <= b;
    end_of_stream_i <= eos;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    advance_deframer(b, eos);
    items_sent++;
  endtask

  task automatic send_bytes(octet_q_t q, int count);
    for (int i = 0; i < count; i++) send_item(q[i], 1'b0);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(frc_pkg::cfg_idx_e idx, logic [frc_pkg::LenW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      frc_pkg::CFG_MAGIC:   cfg_magic = data[7:0];
      frc_pkg::CFG_VERSION: cfg_version = data[7:0];
      frc_pkg::CFG_LENGTH:  cfg_length = data;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [frc_pkg::ByteW-1:0] magic,
                            logic [frc_pkg::ByteW-1:0] version,
                            logic [frc_pkg::LenW-1:0] len);
    wait_idle();
    write_reg(frc_pkg::CFG_MAGIC, {5'($urandom), magic});
    write_reg(frc_pkg::CFG_VERSION, {5'($urandom), version});
    write_reg(frc_pkg::CFG_LENGTH, len);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_boundary_and_hunt();
    send_item(8'h3c, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h01, 1'b0);
    send_item(frc_pkg::MagicReset, 1'b0);
    send_item(frc_pkg::VersionReset, 1'b0);
    send_item(8'h12, 1'b0);
    send_item(8'hff, 1'b1);
    wait_idle();
  endtask

  task automatic test_record_errors();
    octet_q_t pl;
    octet_q_t rec;
    set_config(8'hbe, 8'h00, 13'd2);
    pl = '{8'hff, 8'hff};
    rec = build_record(cfg_magic, cfg_version, fletcher16(pl), pl);
    send_bytes(rec, rec.size());
    pl = '{8'h00, 8'h01};
    rec = build_record(cfg_magic, cfg_version, fletcher16(pl) ^ 16'h0001, pl);
    send_bytes(rec, rec.size());
    pl = '{8'h80, 8'h7f};
    rec = build_record(cfg_magic, cfg_version, fletcher16(pl), pl);
    send_bytes(rec, rec.size());
    send_item(cfg_magic, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(cfg_magic, 1'b0);
    send_item(8'h00, 1'b1);
    pl = '{8'h01, 8'hfe};
    rec = build_record(cfg_magic, cfg_version, fletcher16(pl), pl);
    send_bytes(rec, 5);
    send_item(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_length_change_mid_record();
    octet_q_t pl;
    octet_q_t rec;
    set_config(8'h3c, 8'h5a, 13'd8);
    pl = random_payload(8);
    rec = build_record(cfg_magic, cfg_version, fletcher16(pl), pl);
    send_bytes(rec, 9);
    wait_idle();
    write_reg(frc_pkg::CFG_LENGTH, 13'd3);
    cfg_we_i <= 1'b0;
    send_item(pl[5], 1'b0);
    wait_idle();
  endtask

  task automatic test_length_extremes();
    octet_q_t pl;
    octet_q_t rec;
    for (int s = 0; s < 2; s++) begin
      if (s == 0) set_config(8'h00, 8'hff, 13'd0);
      else set_config(8'hff, 8'h00, 13'd1);
      repeat (2) begin
        pl = random_payload(1);
        rec = build_record(cfg_magic, cfg_version, fletcher16(pl), pl);
        send_bytes(rec, rec.size());
      end
      pl = random_payload(1);
      rec = build_record(cfg_magic, cfg_version, ~fletcher16(pl), pl);
      send_bytes(rec, rec.size());
    end
    tx_no_gaps = 1'b1;
    set_config(8'hbe, 8'h00, 13'd8191);
    pl = random_payload(frc_pkg::MaxPayloadLength);
    rec = build_record(cfg_magic, cfg_version, fletcher16(pl), pl);
    send_bytes(rec, rec.size());
    tx_no_gaps = 1'b0;
    wait_idle();
  endtask

  task automatic test_backpressure();
    octet_q_t pl;
    octet_q_t rec;
    set_config(8'ha5, 8'h01, 13'd4);
    tx_no_gaps = 1'b1;
    rx_hold = 300;
    repeat (6) begin
      pl = random_payload(4);
      rec = build_record(cfg_magic, cfg_version, fletcher16(pl), pl);
      send_bytes(rec, rec.size());
    end
    tx_no_gaps = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_records();
    int       stop_at;
    int       len;
    int       r;
    octet_q_t pl;
    octet_q_t rec;
    stop_at = items_sent + 1100;
    while (items_sent < stop_at) begin
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 48);
      set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 frc_pkg::LenW'(len));
      repeat ($urandom_range(15, 30)) begin
        if (items_sent >= stop_at) break;
        tx_no_gaps = ($urandom_range(0, 7) == 0);
        pl = random_payload(len);
        rec = build_record(cfg_magic, cfg_version, fletcher16(pl), pl);
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send_bytes(rec, rec.size());
        end else if (r < 78) begin
          rec[2] = rec[2] ^ 8'($urandom_range(1, 255));
          send_bytes(rec, rec.size());
        end else if (r < 84) begin
          rec[1] = rec[1] ^ 8'($urandom_range(1, 255));
          send_bytes(rec, 2);
        end else if (r < 90) begin
          send_bytes(rec, $urandom_range(1, rec.size() - 1));
          send_item(8'($urandom), 1'b1);
        end else if (r < 96) begin
          repeat ($urandom_range(1, 4)) send_item(8'($urandom), 1'($urandom_range(0, 4) == 0));
        end else begin
          send_item(8'($urandom), 1'b1);
        end
      end
    end
    tx_no_gaps = 1'b0;
  endtask

  initial begin
    int  run;
    bit  level;
    run = 0;
    level = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        out_stall_i <= 1'b1;
        rx_hold--;
      end else begin
        if (run == 0) begin
          level = ~level;
          if (level) run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                      : $urandom_range(15, 50);
          else run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12)
                                                : $urandom_range(60, 200);
        end
        out_stall_i <= level;
        run--;
      end
    end
  end

  initial begin
    frc_pkg::result_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (frame_results_q.size() == 0) begin
          $error("result with no item pending: status %0h", status_o);
          err_count++;
        end else begin
          want = frame_results_q.pop_front();
          check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte_o));
          check_field("payload_valid", 16'(want.payload_valid), 16'(payload_valid_o));
          check_field("record_end", 16'(want.record_end), 16'(record_end_o));
          check_field("status", 16'(want.status), 16'(status_o));
          check_field("computed_checksum", want.checksum, computed_checksum_o);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_boundary_and_hunt();
    test_record_errors();
    test_length_change_mid_record();
    test_length_extremes();
    test_backpressure();
    test_random_records();
    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
